// File: rtl/aarc_pkg.sv
// Shared types, widths, command codes and scaling constants of the averaged ADC report controller.
package aarc_pkg;

   localparam int unsigned SAMPLE_W = 10;
   localparam int unsigned CMD_W    = 8;
   localparam int unsigned KIND_W   = 3;
   localparam int unsigned MV_W     = 13;
   localparam int unsigned DUTY_W   = 8;
   localparam int unsigned RATE_W   = 6;

   localparam int unsigned RING_DEPTH_DEFAULT  = 8;
   localparam int unsigned MS_PER_STEP_DEFAULT = 100;

   localparam logic [RATE_W-1:0] RATE_MIN   = RATE_W'(1);
   localparam logic [RATE_W-1:0] RATE_MAX   = RATE_W'(50);
   localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(10);

   localparam logic OP_TICK = 1'b0;
   localparam logic OP_CMD  = 1'b1;

   localparam logic [CMD_W-1:0] CMD_CR     = 8'h0D;
   localparam logic [CMD_W-1:0] CMD_LF     = 8'h0A;
   localparam logic [CMD_W-1:0] CMD_READ   = 8'h61;
   localparam logic [CMD_W-1:0] CMD_FASTER = 8'h2B;
   localparam logic [CMD_W-1:0] CMD_SLOWER = 8'h2D;
   localparam logic [CMD_W-1:0] CMD_TOGGLE = 8'h72;
   localparam logic [CMD_W-1:0] CMD_HELP   = 8'h3F;

   typedef enum logic [KIND_W-1:0] {
      KIND_REPORT  = 3'd0,
      KIND_READ    = 3'd1,
      KIND_FASTER  = 3'd2,
      KIND_SLOWER  = 3'd3,
      KIND_TOGGLE  = 3'd4,
      KIND_HELP    = 3'd5,
      KIND_UNKNOWN = 3'd6
   } kind_type;

   // Full-scale scaling: value*5000/1023 and value*255/1023.
   localparam int unsigned MV_SCALE      = 5000;
   localparam int unsigned DUTY_SCALE    = 255;
   localparam int unsigned FULL_SCALE    = 1023;
   localparam int unsigned MV_PROD_W     = 23;
   localparam int unsigned DUTY_PROD_W   = 18;

   // Exact division by 1023 for operands below 2**MV_PROD_W via a reciprocal multiply.
   localparam int unsigned DIV_SH        = MV_PROD_W + 10;
   localparam logic [63:0] DIV_MUL       =
      ((64'd1 << DIV_SH) + 64'(FULL_SCALE) - 64'd1) / 64'(FULL_SCALE);
   localparam int unsigned DIV_MUL_W     = 24;
   localparam int unsigned MV_MUL_W      = MV_PROD_W + DIV_MUL_W;
   localparam int unsigned DUTY_MUL_W    = DUTY_PROD_W + DIV_MUL_W;

endpackage

// File: rtl/aarc_if.sv
// Valid/ready channel interfaces for the request and response sides of the controller.
interface aarc_req_if;
   import aarc_pkg::*;

   logic                valid;
   logic                ready;
   logic                op;
   logic [SAMPLE_W-1:0] sample;
   logic [CMD_W-1:0]    cmd_byte;

   modport source (output valid, output op, output sample, output cmd_byte, input ready);
   modport sink   (input valid, input op, input sample, input cmd_byte, output ready);
endinterface

interface aarc_rsp_if;
   import aarc_pkg::*;

   logic                valid;
   logic                ready;
   logic [KIND_W-1:0]   kind;
   logic [SAMPLE_W-1:0] raw_value;
   logic [MV_W-1:0]     millivolts;
   logic [DUTY_W-1:0]   duty;
   logic [RATE_W-1:0]   rate_now;
   logic                auto_on;

   modport source (output valid, output kind, output raw_value, output millivolts,
                   output duty, output rate_now, output auto_on, input ready);
   modport sink   (input valid, input kind, input raw_value, input millivolts,
                   input duty, input rate_now, input auto_on, output ready);
endinterface

// File: rtl/aarc_ram.sv
// Generic single-write, single-read RAM with a registered, enabled read port.
module aarc_ram #(
   parameter int unsigned WIDTH = 10,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

// File: rtl/averaged_adc_report_controller.sv
// Top level of the averaged ADC report controller: tick and command decode, sample ring, scaling.
//
// The request channel carries one item per transfer: either a millisecond tick with the
// current ADC sample (op = 0) or a console command byte (op = 1). The response channel
// returns at most one item per request: periodic reports of the ring average with its
// millivolt and PWM duty scaling, or the answer to a command. CR and LF produce nothing.
// The block accepts one request per cycle while the response side does not stall it. A
// response passes through the stage 1 to stage 4 registers and the output register:
// decode and ring read, ring update, averaging multiply, scaling multiply, reciprocal
// divide into the output register. The sample ring sits in a RAM read at decode, ahead of
// its update, and consecutive reports always use different slots, so no forwarding is needed.
// Reset is synchronous: the ring reads as zero through per-entry fill flags, the running
// sum and elapsed count clear, the rate returns to ten and auto-report is enabled. When
// the receiver stalls, the pipeline keeps accepting requests until every stage up to the
// output register holds a response; requests that produce no response are always
// absorbed while ready is high.
module averaged_adc_report_controller #(
   parameter int unsigned RING_DEPTH  = aarc_pkg::RING_DEPTH_DEFAULT,
   parameter int unsigned MS_PER_STEP = aarc_pkg::MS_PER_STEP_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   aarc_req_if.sink   req_ch,
   aarc_rsp_if.source rsp_ch
);
   import aarc_pkg::*;

   localparam int unsigned SLOT_W      = $clog2(RING_DEPTH);
   localparam int unsigned TOTAL_W     = SAMPLE_W + SLOT_W;
   localparam int unsigned AVG_SH      = TOTAL_W + SLOT_W;
   localparam logic [63:0] AVG_MUL     =
      ((64'd1 << AVG_SH) + 64'(RING_DEPTH) - 64'd1) / 64'(RING_DEPTH);
   localparam int unsigned AVG_MUL_W   = TOTAL_W + 1;
   localparam int unsigned AVG_PROD_W  = TOTAL_W + AVG_MUL_W;
   localparam int unsigned ELAP_CAP    = 50 * MS_PER_STEP;
   localparam int unsigned ELAP_W      = $clog2(ELAP_CAP + 1);

   // Control state.
   logic [ELAP_W-1:0]     elapsed_ff, elapsed_in;
   logic [RATE_W-1:0]     period_ff, period_in;
   logic                  auto_ff, auto_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   logic [TOTAL_W-1:0]    total_ff;
   logic [RING_DEPTH-1:0] filled_ff;

   // Decode.
   logic                  accept;
   logic                  has_rsp;
   logic                  fire;
   kind_type              kind_in;
   logic [ELAP_W-1:0]     elapsed_inc;
   logic [ELAP_W-1:0]     threshold;

   // Pipeline valids and flow control.
   logic v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic free1, free2, free3, free4, free_out;

   // Stage 1: ring update.
   kind_type            s1_kind_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [SLOT_W-1:0]   s1_slot_ff;
   logic [RATE_W-1:0]   s1_rate_ff;
   logic                s1_auto_ff;
   logic [SAMPLE_W-1:0] ram_rd_data;
   logic [SAMPLE_W-1:0] old_sample;
   logic [TOTAL_W-1:0]  total_in;
   logic                ring_write;

   // Stage 2: average.
   kind_type            s2_kind_ff;
   logic [SAMPLE_W-1:0] s2_sample_ff;
   logic [TOTAL_W-1:0]  s2_total_ff;
   logic [RATE_W-1:0]   s2_rate_ff;
   logic                s2_auto_ff;
   logic [AVG_PROD_W-1:0] avg_prod;
   logic [SAMPLE_W-1:0] raw_in;

   // Stage 3: scaling products.
   kind_type            s3_kind_ff;
   logic [SAMPLE_W-1:0] s3_raw_ff;
   logic [RATE_W-1:0]   s3_rate_ff;
   logic                s3_auto_ff;

   // Stage 4: divide by full scale.
   kind_type             s4_kind_ff;
   logic [SAMPLE_W-1:0]  s4_raw_ff;
   logic [MV_PROD_W-1:0] s4_mv_prod_ff;
   logic [DUTY_PROD_W-1:0] s4_duty_prod_ff;
   logic [RATE_W-1:0]    s4_rate_ff;
   logic                 s4_auto_ff;
   logic [MV_MUL_W-1:0]  mv_full;
   logic [DUTY_MUL_W-1:0] duty_full;

   // Output register.
   kind_type            out_kind_ff;
   logic [SAMPLE_W-1:0] out_raw_ff;
   logic [MV_W-1:0]     out_mv_ff;
   logic [DUTY_W-1:0]   out_duty_ff;
   logic [RATE_W-1:0]   out_rate_ff;
   logic                out_auto_ff;

   assign free_out = !rsp_valid_ff || rsp_ch.ready;
   assign free4    = !v4_ff || free_out;
   assign free3    = !v3_ff || free4;
   assign free2    = !v2_ff || free3;
   assign free1    = !v1_ff || free2;

   assign req_ch.ready = free1;
   assign accept       = req_ch.valid && free1;

   assign elapsed_inc = (elapsed_ff < ELAP_W'(ELAP_CAP)) ? elapsed_ff + ELAP_W'(1) : elapsed_ff;
   assign threshold   = ELAP_W'(period_ff) * ELAP_W'(MS_PER_STEP);
   assign fire        = accept && (req_ch.op == OP_TICK) && auto_ff && (elapsed_inc >= threshold);

   always_comb begin
      elapsed_in = elapsed_ff;
      period_in  = period_ff;
      auto_in    = auto_ff;
      slot_in    = slot_ff;
      has_rsp    = 1'b0;
      kind_in    = KIND_UNKNOWN;
      if (accept) begin
         if (req_ch.op == OP_TICK) begin
            elapsed_in = fire ? '0 : elapsed_inc;
            if (fire) begin
               has_rsp = 1'b1;
               kind_in = KIND_REPORT;
               slot_in = (slot_ff == SLOT_W'(RING_DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
            end
         end else begin
            has_rsp = 1'b1;
            case (req_ch.cmd_byte)
               CMD_CR, CMD_LF: begin
                  has_rsp = 1'b0;
               end
               CMD_READ: begin
                  kind_in = KIND_READ;
               end
               CMD_FASTER: begin
                  kind_in = KIND_FASTER;
                  if (period_ff > RATE_MIN) begin
                     period_in = period_ff - RATE_W'(1);
                  end
               end
               CMD_SLOWER: begin
                  kind_in = KIND_SLOWER;
                  if (period_ff < RATE_MAX) begin
                     period_in = period_ff + RATE_W'(1);
                  end
               end
               CMD_TOGGLE: begin
                  kind_in = KIND_TOGGLE;
                  auto_in = !auto_ff;
               end
               CMD_HELP: begin
                  kind_in = KIND_HELP;
               end
               default: begin
                  kind_in = KIND_UNKNOWN;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         elapsed_ff <= '0;
         period_ff  <= RATE_RESET;
         auto_ff    <= 1'b1;
         slot_ff    <= '0;
      end else begin
         elapsed_ff <= elapsed_in;
         period_ff  <= period_in;
         auto_ff    <= auto_in;
         slot_ff    <= slot_in;
      end
   end

   aarc_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ring_write),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_sample_ff),
      .rd_en   (fire),
      .rd_addr (slot_ff),
      .rd_data (ram_rd_data)
   );

   // Stage 1 register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (free1) begin
         v1_ff <= accept && has_rsp;
      end
      if (free1) begin
         s1_kind_ff   <= kind_in;
         s1_sample_ff <= req_ch.sample;
         s1_slot_ff   <= slot_ff;
         s1_rate_ff   <= period_in;
         s1_auto_ff   <= auto_in;
      end
   end

   assign ring_write = v1_ff && free2 && (s1_kind_ff == KIND_REPORT);
   assign old_sample = filled_ff[s1_slot_ff] ? ram_rd_data : '0;
   assign total_in   = total_ff - TOTAL_W'(old_sample) + TOTAL_W'(s1_sample_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff  <= '0;
         filled_ff <= '0;
      end else if (ring_write) begin
         total_ff              <= total_in;
         filled_ff[s1_slot_ff] <= 1'b1;
      end
   end

   // Stage 2 register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (free2) begin
         v2_ff <= v1_ff;
      end
      if (free2) begin
         s2_kind_ff   <= s1_kind_ff;
         s2_sample_ff <= s1_sample_ff;
         s2_total_ff  <= total_in;
         s2_rate_ff   <= s1_rate_ff;
         s2_auto_ff   <= s1_auto_ff;
      end
   end

   assign avg_prod = AVG_PROD_W'(s2_total_ff) * AVG_PROD_W'(AVG_MUL);

   always_comb begin
      case (s2_kind_ff)
         KIND_REPORT: raw_in = avg_prod[AVG_SH +: SAMPLE_W];
         KIND_READ:   raw_in = s2_sample_ff;
         default:     raw_in = '0;
      endcase
   end

   // Stage 3 register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (free3) begin
         v3_ff <= v2_ff;
      end
      if (free3) begin
         s3_kind_ff <= s2_kind_ff;
         s3_raw_ff  <= raw_in;
         s3_rate_ff <= s2_rate_ff;
         s3_auto_ff <= s2_auto_ff;
      end
   end

   // Stage 4 register.
   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (free4) begin
         v4_ff <= v3_ff;
      end
      if (free4) begin
         s4_kind_ff      <= s3_kind_ff;
         s4_raw_ff       <= s3_raw_ff;
         s4_mv_prod_ff   <= MV_PROD_W'(s3_raw_ff) * MV_PROD_W'(MV_SCALE);
         s4_duty_prod_ff <= DUTY_PROD_W'(s3_raw_ff) * DUTY_PROD_W'(DUTY_SCALE);
         s4_rate_ff      <= s3_rate_ff;
         s4_auto_ff      <= s3_auto_ff;
      end
   end

   assign mv_full   = MV_MUL_W'(s4_mv_prod_ff) * MV_MUL_W'(DIV_MUL);
   assign duty_full = DUTY_MUL_W'(s4_duty_prod_ff) * DUTY_MUL_W'(DIV_MUL);

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (free_out) begin
         rsp_valid_ff <= v4_ff;
      end
      if (free_out) begin
         out_kind_ff <= s4_kind_ff;
         out_raw_ff  <= s4_raw_ff;
         out_mv_ff   <= mv_full[DIV_SH +: MV_W];
         out_duty_ff <= (s4_kind_ff == KIND_REPORT) ? duty_full[DIV_SH +: DUTY_W] : '0;
         out_rate_ff <= s4_rate_ff;
         out_auto_ff <= s4_auto_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.kind       = out_kind_ff;
   assign rsp_ch.raw_value  = out_raw_ff;
   assign rsp_ch.millivolts = out_mv_ff;
   assign rsp_ch.duty       = out_duty_ff;
   assign rsp_ch.rate_now   = out_rate_ff;
   assign rsp_ch.auto_on    = out_auto_ff;
endmodule

// File: sim/tb.sv
// Testbench for the averaged ADC report controller, checking every response against a predictor.
module tb;
   import aarc_pkg::*;

   localparam int unsigned TAPS          = RING_DEPTH_DEFAULT;
   localparam int unsigned STEP_MS       = MS_PER_STEP_DEFAULT;
   localparam int unsigned MS_CAP        = int'(RATE_MAX) * STEP_MS;
   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned RANDOM_ITEMS  = 300;
   localparam int unsigned REPORT_COUNT  = TAPS + 2;
   localparam int unsigned PAUSE_TICKS   = (3 * STEP_MS) / 2;
   localparam int unsigned IDLE_DEFAULT  = 17;
   localparam logic [CMD_W-1:0] CMD_OVERSAMPLE = 8'h6F;
   localparam logic [CMD_W-1:0] BYTE_MIN       = 8'h00;
   localparam logic [CMD_W-1:0] BYTE_MAX       = 8'hFF;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MIN  = '0;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MAX  = '1;

   typedef struct packed {
      kind_type            kind;
      logic [SAMPLE_W-1:0] raw_value;
      logic [MV_W-1:0]     millivolts;
      logic [DUTY_W-1:0]   duty;
      logic [RATE_W-1:0]   rate_now;
      logic                auto_on;
   } answer_type;

   logic clock = 1'b0;
   logic reset;

   aarc_req_if req_ch ();
   aarc_rsp_if rsp_ch ();

   averaged_adc_report_controller u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // Predictor state.
   int unsigned avg_ring [TAPS];
   int unsigned avg_slot;
   int unsigned avg_sum;
   int unsigned rate_steps;
   bit          auto_flag;
   int unsigned ms_count;

   answer_type  pending_answers [$];
   answer_type  want;
   int unsigned errors = 0;
   int unsigned cycles = 0;
   int unsigned reports_due;
   int unsigned sent_items;
   int unsigned idle_pct;
   int unsigned stall_pct;

   task automatic reset_model();
      foreach (avg_ring[i]) avg_ring[i] = 0;
      avg_slot   = 0;
      avg_sum    = 0;
      rate_steps = int'(RATE_RESET);
      auto_flag  = 1'b1;
      ms_count   = 0;
   endtask

   task automatic compute_answer(input logic op, input logic [SAMPLE_W-1:0] s,
                                 input logic [CMD_W-1:0] c);
      answer_type  a;
      bit          has_answer;
      int unsigned avg;
      a = '0;
      has_answer = 1'b0;
      if (op == OP_TICK) begin
         if (ms_count < MS_CAP) ms_count++;
         if (auto_flag && ms_count >= rate_steps * STEP_MS) begin
            avg_sum = avg_sum - avg_ring[avg_slot] + s;
            avg_ring[avg_slot] = s;
            avg_slot = (avg_slot + 1) % TAPS;
            avg = avg_sum / TAPS;
            ms_count = 0;
            a.kind       = KIND_REPORT;
            a.raw_value  = SAMPLE_W'(avg);
            a.millivolts = MV_W'(avg * MV_SCALE / FULL_SCALE);
            a.duty       = DUTY_W'(avg * DUTY_SCALE / FULL_SCALE);
            has_answer   = 1'b1;
            reports_due++;
         end
      end else begin
         has_answer = 1'b1;
         case (c)
            CMD_CR, CMD_LF: has_answer = 1'b0;
            CMD_READ: begin
               a.kind       = KIND_READ;
               a.raw_value  = s;
               a.millivolts = MV_W'(int'(s) * MV_SCALE / FULL_SCALE);
            end
            CMD_FASTER: begin
               if (rate_steps > int'(RATE_MIN)) rate_steps--;
               a.kind = KIND_FASTER;
            end
            CMD_SLOWER: begin
               if (rate_steps < int'(RATE_MAX)) rate_steps++;
               a.kind = KIND_SLOWER;
            end
            CMD_TOGGLE: begin
               auto_flag = !auto_flag;
               a.kind = KIND_TOGGLE;
            end
            CMD_HELP: a.kind = KIND_HELP;
            default:  a.kind = KIND_UNKNOWN;
         endcase
      end
      a.rate_now = RATE_W'(rate_steps);
      a.auto_on  = auto_flag;
      if (has_answer) pending_answers.push_back(a);
   endtask

   // The expectation is recorded at the edge where the transfer happens.
   task automatic send_item(input logic op, input logic [SAMPLE_W-1:0] s,
                            input logic [CMD_W-1:0] c);
      while ($urandom_range(99) < idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.op       <= op;
      req_ch.sample   <= s;
      req_ch.cmd_byte <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      compute_answer(op, s, c);
      sent_items++;
   endtask

   function automatic logic [SAMPLE_W-1:0] rand_sample();
      logic [SAMPLE_W-1:0] v;
      case ($urandom_range(7))
         0:       v = SAMPLE_MIN;
         1:       v = SAMPLE_MAX;
         default: v = SAMPLE_W'($urandom_range(1023));
      endcase
      return v;
   endfunction

   task automatic send_tick(input logic [SAMPLE_W-1:0] s);
      send_item(OP_TICK, s, CMD_W'($urandom_range(255)));
   endtask

   task automatic send_cmd(input logic [CMD_W-1:0] c);
      send_item(OP_CMD, SAMPLE_W'($urandom_range(1023)), c);
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_cmd(CMD_CR);
      send_cmd(CMD_LF);
      send_item(OP_CMD, SAMPLE_MIN, CMD_READ);
      send_item(OP_CMD, SAMPLE_MAX, CMD_READ);
      send_cmd(CMD_HELP);
      send_cmd(CMD_OVERSAMPLE);
      send_cmd(BYTE_MIN);
      send_cmd(BYTE_MAX);
      send_tick(SAMPLE_MIN);
      send_tick(SAMPLE_MAX);
      send_cmd(CMD_TOGGLE);
      send_cmd(CMD_TOGGLE);
      send_cmd(CMD_SLOWER);
      repeat (12) send_cmd(CMD_FASTER);
      wait_idle();
   endtask

   // At the fastest rate; the first eight reports fill the ring with full-scale samples
   // and the last ones overwrite them.
   task automatic test_reports();
      int unsigned base;
      int unsigned n;
      logic [SAMPLE_W-1:0] s;
      base = reports_due;
      while (reports_due - base < REPORT_COUNT) begin
         n = reports_due - base;
         s = (n < TAPS) ? SAMPLE_MAX : rand_sample();
         case ($urandom_range(49))
            0:       send_item(OP_CMD, s, CMD_READ);
            1:       send_cmd(CMD_FASTER);
            default: send_tick(s);
         endcase
      end
      wait_idle();
   endtask

   task automatic test_auto_pause();
      send_cmd(CMD_TOGGLE);
      repeat (PAUSE_TICKS) send_tick(rand_sample());
      send_cmd(CMD_TOGGLE);
      send_tick(rand_sample());
      repeat (int'(RATE_MAX) + 1) send_cmd(CMD_SLOWER);
      wait_idle();
   endtask

   task automatic test_random();
      int unsigned start;
      int unsigned pick;
      int unsigned k;
      bit          paused;
      logic [CMD_W-1:0] dir;
      start  = sent_items;
      paused = 1'b0;
      while (sent_items - start < RANDOM_ITEMS) begin
         k = sent_items - start;
         if (k >= 100 && k < 200) begin
            idle_pct  = 0;
            stall_pct = 0;
         end else begin
            idle_pct  = IDLE_DEFAULT;
            stall_pct = IDLE_DEFAULT;
         end
         if (k >= 220 && !paused) begin
            paused = 1'b1;
            wait_idle();
         end
         pick = $urandom_range(99);
         if (pick < 2) begin
            dir = $urandom_range(1) ? CMD_SLOWER : CMD_FASTER;
            repeat ($urandom_range(60, 20)) send_cmd(dir);
         end else if (pick < 57) begin
            send_tick(rand_sample());
         end else begin
            pick = pick - 57;
            if (pick < 12)      send_cmd(CMD_FASTER);
            else if (pick < 17) send_cmd(CMD_SLOWER);
            else if (pick < 22) send_item(OP_CMD, rand_sample(), CMD_READ);
            else if (pick < 25) send_cmd(CMD_TOGGLE);
            else if (pick < 28) send_cmd(CMD_HELP);
            else if (pick < 30) send_cmd(CMD_CR);
            else if (pick < 32) send_cmd(CMD_LF);
            else                send_cmd(CMD_W'($urandom_range(255)));
         end
      end
      idle_pct  = IDLE_DEFAULT;
      stall_pct = IDLE_DEFAULT;
      wait_idle();
   endtask

   task automatic check_field(input string label, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, label, exp_val, act_val);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response: expected none, actual kind %0d raw %0d",
                     $time, rsp_ch.kind, rsp_ch.raw_value);
            errors++;
         end else begin
            want = pending_answers.pop_front();
            check_field("kind", want.kind, rsp_ch.kind);
            check_field("raw_value", want.raw_value, rsp_ch.raw_value);
            check_field("millivolts", want.millivolts, rsp_ch.millivolts);
            check_field("duty", want.duty, rsp_ch.duty);
            check_field("rate_now", want.rate_now, rsp_ch.rate_now);
            check_field("auto_on", want.auto_on, rsp_ch.auto_on);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[averaged_adc_report_controller] ERROR");
         $finish;
      end
   end

   initial begin
      reports_due = 0;
      sent_items  = 0;
      idle_pct    = IDLE_DEFAULT;
      stall_pct   = IDLE_DEFAULT;
      reset_model();
      reset           <= 1'b1;
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_TICK;
      req_ch.sample   <= '0;
      req_ch.cmd_byte <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_reports();
      test_auto_pause();
      test_random();

      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      if (errors == 0 && pending_answers.size() == 0) begin
         $display("[averaged_adc_report_controller] OK");
      end else begin
         $display("[averaged_adc_report_controller] ERROR");
      end
      $finish;
   end

endmodule

// File: files.f
rtl/aarc_pkg.sv
rtl/aarc_if.sv
rtl/aarc_ram.sv
rtl/averaged_adc_report_controller.sv
sim/tb.sv
